// ----- rtl/dictionary_prefix_cover_defines.svh -----
// Assertion macros used by the checker module dpc_checker.
`ifndef DICTIONARY_PREFIX_COVER_DEFINES_SVH
`define DICTIONARY_PREFIX_COVER_DEFINES_SVH

// The consequence must hold in the same cycle as the antecedent.
`define DPC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dictionary_prefix_cover check failed");

// The consequence must hold in the cycle after the antecedent.
`define DPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dictionary_prefix_cover check failed");

`endif

// ----- rtl/dpc_pkg.sv -----
package dpc_pkg;
	localparam int NUM_WORDS    = 256;
	localparam int MAX_WORD_LEN = 16;
	localparam int MAX_TEXT     = 262144;

	localparam int SLOT_W = 8;
	localparam int IDX_W  = 4;
	localparam int LEN_W  = 5;
	localparam int POS_W  = 19;
	localparam int CHAR_W = 8;
	localparam int ROW_W  = MAX_WORD_LEN * CHAR_W;

	typedef enum logic [1:0] {
		MODE_CHAR    = 2'd0,
		MODE_LEN     = 2'd1,
		MODE_TEXT    = 2'd2,
		MODE_RESTART = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_LAST
	} state_t;

	typedef struct packed {
		logic              wr_char;
		logic              wr_len;
		logic              wr_zero;
		logic              rd;
		logic [SLOT_W-1:0] wr_slot;
		logic [SLOT_W-1:0] rd_slot;
		logic [IDX_W-1:0]  cpos;
		logic [CHAR_W-1:0] cval;
		logic [LEN_W-1:0]  plen;
	} dict_req_t;

	typedef struct packed {
		logic shift_char;
		logic shift_reach;
		logic clear;
	} cell_ctl_t;
endpackage

// ----- rtl/dictionary_prefix_cover.sv -----
// Dictionary prefix cover: reports the longest text prefix that splits into dictionary words.
// Input items arrive on the s_ channel; s_tuser selects the kind of item: write a word
// character, set a word length (zero disables a slot), push a text byte, or restart the text.
// Every accepted item yields exactly one result item on the m_ channel carrying the longest
// covered prefix, the text position, whether the current position is covered and the
// overflow flag. Dictionary writes, restarts and text bytes dropped at the text limit give
// their result in the cycle after acceptance. A text byte enters a row of 16 cells that hold
// the recent text window and reach bits, then the 256 dictionary slots are read from the
// word memory one per cycle and checked against the cells. Its result is registered in
// state ST_LAST, which follows the scan, and the next item is taken only once the block is
// back in idle, so a text byte holds the block for the whole scan of the word memory.
// After reset the word memory is cleared one slot per cycle with s_tready low.
// One item is in work at a time. A new item is taken while the previous result is being
// taken; a stalled receiver holds the result and holds s_tready low.
module dictionary_prefix_cover (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // pattern_slot, char_position, char_value, pattern_length
	input  logic [1:0]  s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // longest_prefix, text_position, reachable_here, overflow
);
	import dpc_pkg::*;

	state_t            state_q, state_d;
	logic [SLOT_W-1:0] clr_q, scan_q;
	logic              rvalid_s1, hit_q;
	logic [POS_W-1:0]  pos_q, best_q, pos_d, best_d, newpos;
	logic              ovf_q, ovf_d;
	logic              out_valid_q, out_reach_q, out_ovf_q;
	logic [POS_W-1:0]  out_best_q, out_pos_q;
	logic              out_load, nr, no;
	logic [POS_W-1:0]  nb, np;

	mode_t             mode;
	logic [SLOT_W-1:0] slot;
	logic [IDX_W-1:0]  cpos;
	logic [CHAR_W-1:0] cval;
	logic [LEN_W-1:0]  plen;
	logic              accept, text_full, match, len_ok, reach_in, r;

	dict_req_t         req;
	cell_ctl_t         ctl;
	logic [ROW_W-1:0]  row_s1;
	logic [LEN_W-1:0]  len_s1;

	logic [CHAR_W-1:0]       char_v [MAX_WORD_LEN];
	logic [MAX_WORD_LEN-1:0] reach_v, ok_v, tap_v;

	assign mode = mode_t'(s_tuser);
	assign slot = s_tdata[7:0];
	assign cpos = s_tdata[11:8];
	assign cval = s_tdata[19:12];
	assign plen = s_tdata[24:20];

	assign s_tready  = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign text_full = pos_q >= POS_W'(MAX_TEXT);
	assign newpos    = pos_q + POS_W'(1);

	dpc_dict u_dict (
		.clk    (clk),
		.req    (req),
		.row_s1 (row_s1),
		.len_s1 (len_s1)
	);

	for (genvar k = 0; k < MAX_WORD_LEN; k++) begin : g_cell
		logic [CHAR_W-1:0] cin;
		logic              rin;
		if (k == 0) begin : g_head
			assign cin = cval;
			assign rin = reach_in;
		end else begin : g_link
			assign cin = char_v[k-1];
			assign rin = reach_v[k-1];
		end
		dpc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.index    (IDX_W'(k)),
			.char_in  (cin),
			.reach_in (rin),
			.row      (row_s1),
			.len      (len_s1),
			.char_q   (char_v[k]),
			.reach_q  (reach_v[k]),
			.ok       (ok_v[k]),
			.tap      (tap_v[k])
		);
	end

	assign len_ok = (len_s1 != '0) && (len_s1 <= LEN_W'(MAX_WORD_LEN))
		&& (POS_W'(len_s1) <= newpos);
	assign match  = rvalid_s1 && len_ok && (&ok_v) && (|tap_v);
	assign r      = hit_q || match;

	always_comb begin
		state_d  = state_q;
		req      = '0;
		ctl      = '0;
		reach_in = 1'b0;
		out_load = 1'b0;
		pos_d    = pos_q;
		best_d   = best_q;
		ovf_d    = ovf_q;
		nb       = best_q;
		np       = pos_q;
		nr       = reach_v[0];
		no       = ovf_q;
		req.cpos = cpos;
		req.cval = cval;
		req.plen = plen;
		req.wr_slot = slot;
		case (state_q)
			ST_CLEAR: begin
				req.wr_zero = 1'b1;
				req.wr_slot = clr_q;
				if (clr_q == SLOT_W'(NUM_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					out_load = 1'b1;
					case (mode)
						MODE_CHAR: begin
							req.wr_char = (32'(slot) < NUM_WORDS) && (32'(cpos) < MAX_WORD_LEN);
						end
						MODE_LEN: begin
							req.wr_len = 32'(slot) < NUM_WORDS;
						end
						MODE_TEXT: begin
							if (text_full) begin
								ovf_d = 1'b1;
								no    = 1'b1;
							end else begin
								ctl.shift_char = 1'b1;
								out_load       = 1'b0;
								state_d        = ST_SCAN;
							end
						end
						MODE_RESTART: begin
							ctl.clear = 1'b1;
							pos_d     = '0;
							best_d    = '0;
							ovf_d     = 1'b0;
							nb        = '0;
							np        = '0;
							nr        = 1'b1;
							no        = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				req.rd      = 1'b1;
				req.rd_slot = scan_q;
				if (scan_q == SLOT_W'(NUM_WORDS - 1)) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				ctl.shift_reach = 1'b1;
				reach_in        = r;
				pos_d           = newpos;
				if (r) begin
					best_d = newpos;
				end
				out_load = 1'b1;
				nb       = r ? newpos : best_q;
				np       = newpos;
				nr       = r;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			scan_q      <= '0;
			rvalid_s1   <= 1'b0;
			hit_q       <= 1'b0;
			pos_q       <= '0;
			best_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_q     <= (state_q == ST_CLEAR) ? clr_q + SLOT_W'(1) : '0;
			scan_q    <= (state_q == ST_SCAN) ? scan_q + SLOT_W'(1) : '0;
			rvalid_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_IDLE) begin
				hit_q <= 1'b0;
			end else if (match) begin
				hit_q <= 1'b1;
			end
			pos_q  <= pos_d;
			best_q <= best_d;
			ovf_q  <= ovf_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_best_q  <= nb;
			out_pos_q   <= np;
			out_reach_q <= nr;
			out_ovf_q   <= no;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_ovf_q, out_reach_q, out_pos_q, out_best_q};
endmodule

// ----- rtl/dpc_dict.sv -----
module dpc_dict (
	input  logic                         clk,
	input  dpc_pkg::dict_req_t           req,
	output logic [dpc_pkg::ROW_W-1:0]    row_s1,
	output logic [dpc_pkg::LEN_W-1:0]    len_s1
);
	import dpc_pkg::*;

	logic [ROW_W-1:0] chars_mem [NUM_WORDS];
	logic [LEN_W-1:0] len_mem [NUM_WORDS];

	always_ff @(posedge clk) begin
		if (req.wr_zero) begin
			chars_mem[req.wr_slot] <= '0;
			len_mem[req.wr_slot]   <= '0;
		end else begin
			if (req.wr_char) begin
				chars_mem[req.wr_slot][req.cpos*CHAR_W +: CHAR_W] <= req.cval;
			end
			if (req.wr_len) begin
				len_mem[req.wr_slot] <= req.plen;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			row_s1 <= chars_mem[req.rd_slot];
			len_s1 <= len_mem[req.rd_slot];
		end
	end
endmodule

// ----- rtl/dpc_cell.sv -----
module dpc_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dpc_pkg::cell_ctl_t           ctl,
	input  logic [dpc_pkg::IDX_W-1:0]    index,
	input  logic [dpc_pkg::CHAR_W-1:0]   char_in,
	input  logic                         reach_in,
	input  logic [dpc_pkg::ROW_W-1:0]    row,
	input  logic [dpc_pkg::LEN_W-1:0]    len,
	output logic [dpc_pkg::CHAR_W-1:0]   char_q,
	output logic                         reach_q,
	output logic                         ok,
	output logic                         tap
);
	import dpc_pkg::*;

	logic [LEN_W-1:0]  k_ext;
	logic [LEN_W-1:0]  widx;
	logic [CHAR_W-1:0] wch;

	assign k_ext = LEN_W'(index);
	assign widx  = len - k_ext - LEN_W'(1);
	assign wch   = row[widx[IDX_W-1:0]*CHAR_W +: CHAR_W];
	assign ok    = (k_ext >= len) || (char_q == wch);
	assign tap   = reach_q && ((k_ext + LEN_W'(1)) == len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q  <= '0;
			reach_q <= (index == '0);
		end else if (ctl.clear) begin
			char_q  <= '0;
			reach_q <= (index == '0);
		end else begin
			if (ctl.shift_char) begin
				char_q <= char_in;
			end
			if (ctl.shift_reach) begin
				reach_q <= reach_in;
			end
		end
	end
endmodule

// ----- rtl/dpc_checker.sv -----
`include "dictionary_prefix_cover_defines.svh"

module dpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);
	import dpc_pkg::*;

	`DPC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`DPC_ASSERT_NEXT(a_one_result, s_tvalid && s_tready, m_tvalid || !s_tready)
	`DPC_ASSERT_NOW(a_pos_limit, m_tvalid, m_tdata[37:19] <= POS_W'(MAX_TEXT))
	`DPC_ASSERT_NOW(a_best_le_pos, m_tvalid, m_tdata[18:0] <= m_tdata[37:19])
	`DPC_ASSERT_NOW(a_reach_best, m_tvalid && m_tdata[38], m_tdata[18:0] == m_tdata[37:19])
endmodule

bind dictionary_prefix_cover dpc_checker u_dpc_checker (.*);
